// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the datapath and controller rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif

`endif

// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

   localparam int CHAR_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int CELL_W     = CHAR_W + COLOR_W;
   localparam int CURSOR_W   = 11;
   localparam int ROW_IN_W   = 5;
   localparam int COL_IN_W   = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CHAR_W-1:0]    NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]    SPACE_CODE   = 8'd32;
   localparam logic [COLOR_W-1:0]   RESET_COLOR  = 8'd7;

   localparam logic                 KIND_PUT  = 1'b0;
   localparam logic                 KIND_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_TEXT_COLOR = CSR_IDX_W'(0);

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic clear_step;
      logic exec_put;
      logic exec_read;
      logic load_read;
      logic scroll_start;
      logic scroll_step;
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic kind_read;
      logic scroll_needed;
      logic sweep_last;
   } dp_status_type;

endpackage

// ===== rtl/tcw_if.sv =====
interface tcw_req_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [tcw_pkg::CHAR_W-1:0]     char_code;
   logic [tcw_pkg::ROW_IN_W-1:0]   read_row;
   logic [tcw_pkg::COL_IN_W-1:0]   read_col;

   modport source (output valid, kind, char_code, read_row, read_col, input ready);
   modport sink   (input valid, kind, char_code, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tcw_pkg::CURSOR_W-1:0]   cursor_position;
   logic [tcw_pkg::CELL_W-1:0]     cell_value;

   modport source (output valid, cursor_position, cell_value, input ready);
   modport sink   (input valid, cursor_position, cell_value, output ready);
endinterface

// ===== rtl/tcw_datapath.sv =====
`include "assert_macros.svh"

module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcw_pkg::dp_cmd_type               cmd,
   output tcw_pkg::dp_status_type            status,
   input  logic                              req_kind,
   input  logic [tcw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tcw_pkg::ROW_IN_W-1:0]      req_read_row,
   input  logic [tcw_pkg::COL_IN_W-1:0]      req_read_col,
   input  logic [tcw_pkg::COLOR_W-1:0]       text_color,
   output logic [tcw_pkg::CURSOR_W-1:0]      rsp_cursor_position,
   output logic [tcw_pkg::CELL_W-1:0]        rsp_cell_value
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int MOVE   = (ROWS - 1) * COLUMNS;
   localparam int RA_W   = tcw_pkg::ROW_IN_W + tcw_pkg::COL_IN_W + 1;
   localparam int SUM_W  = (ADDR_W + 1 > tcw_pkg::CURSOR_W) ? ADDR_W + 1 : tcw_pkg::CURSOR_W;

   logic [tcw_pkg::CELL_W-1:0]   mem [CELLS];

   logic                         kind_ff;
   logic [tcw_pkg::CHAR_W-1:0]   char_ff;
   logic [ADDR_W-1:0]            rd_addr_ff;
   logic                         rd_ok_ff;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [COL_W-1:0]             col_ff, col_in;
   logic [ADDR_W-1:0]            base_ff, base_in;
   logic [tcw_pkg::CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [ADDR_W-1:0]            sweep_ff, sweep_in;
   logic [tcw_pkg::CELL_W-1:0]   rd_data_ff;
   logic [tcw_pkg::CURSOR_W-1:0] rsp_cursor_ff;
   logic [tcw_pkg::CELL_W-1:0]   rsp_cell_ff;

   logic                         is_newline, last_col, last_row, wrap, in_move;
   logic [ADDR_W-1:0]            wr_addr, base_adv;
   logic [ADDR_W:0]              sweep_nxt;
   logic [SUM_W-1:0]             cur_sum;
   logic [RA_W-1:0]              rd_lin;
   logic                         rd_ok_in;
   logic                         mem_we, mem_re;
   logic [ADDR_W-1:0]            mem_waddr, mem_raddr;
   logic [tcw_pkg::CELL_W-1:0]   mem_wdata;

   // read address of a read item, taken at accept
   assign rd_lin   = RA_W'(req_read_row) * RA_W'(COLUMNS) + RA_W'(req_read_col);
   assign rd_ok_in = ({2'b00, req_read_row} < 7'(ROWS)) && ({1'b0, req_read_col} < 8'(COLUMNS));

   assign is_newline = (char_ff == tcw_pkg::NEWLINE_CODE);
   assign last_col   = (col_ff == COL_W'(COLUMNS - 1));
   assign last_row   = (row_ff == ROW_W'(ROWS - 1));
   assign wrap       = is_newline || last_col;
   assign wr_addr    = base_ff + ADDR_W'(col_ff);
   assign base_adv   = last_row ? base_ff : base_ff + ADDR_W'(COLUMNS);
   assign sweep_nxt  = (ADDR_W + 1)'(sweep_ff) + (ADDR_W + 1)'(1);
   assign in_move    = (sweep_ff < ADDR_W'(MOVE));

   // newline puts the cursor at the new line start, a character just after itself
   assign cur_sum   = is_newline ? SUM_W'(base_adv) : SUM_W'(wr_addr) + SUM_W'(1);
   assign cursor_in = cur_sum[tcw_pkg::CURSOR_W-1:0];

   assign status.kind_read     = (kind_ff == tcw_pkg::KIND_READ);
   assign status.scroll_needed = (kind_ff == tcw_pkg::KIND_PUT) && wrap && last_row;
   assign status.sweep_last    = (sweep_ff == ADDR_W'(CELLS - 1));

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      base_in = base_ff;
      if (cmd.exec_put) begin
         if (wrap) begin
            col_in = '0;
            if (!last_row) begin
               row_in  = row_ff + ROW_W'(1);
               base_in = base_ff + ADDR_W'(COLUMNS);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end

      sweep_in = sweep_ff;
      if (cmd.clear_step || cmd.scroll_step) begin
         sweep_in = status.sweep_last ? '0 : sweep_nxt[ADDR_W-1:0];
      end
   end

   // memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::SPACE_CODE};
      mem_re    = 1'b0;
      mem_raddr = rd_addr_ff;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end
      if (cmd.exec_put && !is_newline) begin
         mem_we    = 1'b1;
         mem_waddr = wr_addr;
         mem_wdata = {text_color, char_ff};
      end
      if (cmd.exec_read) begin
         mem_re = rd_ok_ff;
      end
      if (cmd.scroll_start) begin
         mem_re    = 1'b1;
         mem_raddr = ADDR_W'(COLUMNS);
      end
      if (cmd.scroll_step) begin
         mem_we    = 1'b1;
         mem_wdata = in_move ? rd_data_ff : {text_color, tcw_pkg::SPACE_CODE};
         mem_re    = (sweep_nxt < (ADDR_W + 1)'(MOVE));
         mem_raddr = ADDR_W'(sweep_nxt + (ADDR_W + 1)'(COLUMNS));
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         col_ff    <= '0;
         base_ff   <= '0;
         cursor_ff <= '0;
         sweep_ff  <= '0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         base_ff  <= base_in;
         sweep_ff <= sweep_in;
         if (cmd.exec_put) begin
            cursor_ff <= cursor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req_kind;
         char_ff    <= req_char_code;
         rd_addr_ff <= rd_lin[ADDR_W-1:0];
         rd_ok_ff   <= rd_ok_in;
      end
      if (cmd.exec_put) begin
         rsp_cursor_ff <= cursor_in;
         rsp_cell_ff   <= '0;
      end
      if (cmd.load_read) begin
         rsp_cursor_ff <= cursor_ff;
         rsp_cell_ff   <= rd_ok_ff ? rd_data_ff : '0;
      end
   end

   assign rsp_cursor_position = rsp_cursor_ff;
   assign rsp_cell_value      = rsp_cell_ff;

   `ASSERT_CLKD(a_col_range, clock, reset, col_ff <= COL_W'(COLUMNS - 1), "write column out of range")
   `ASSERT_CLKD(a_base_row, clock, reset, base_ff == ADDR_W'(row_ff) * ADDR_W'(COLUMNS), "line base lost track of row")
   `ASSERT_CLKD(a_sweep_idle, clock, reset, (!cmd.clear_step && !cmd.scroll_step) |-> sweep_ff == '0, "sweep counter not parked")

endmodule

// ===== rtl/tcw_ctrl.sv =====
`include "assert_macros.svh"

module tcw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tcw_pkg::dp_cmd_type     cmd,
   input  tcw_pkg::dp_status_type  status
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ_DONE,
      ST_SCROLL
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd              = '0;
      cmd.capture      = accept;
      cmd.clear_step   = (state_ff == ST_CLEAR);
      cmd.exec_put     = (state_ff == ST_EXEC) && !status.kind_read;
      cmd.exec_read    = (state_ff == ST_EXEC) && status.kind_read;
      cmd.load_read    = (state_ff == ST_READ_DONE);
      cmd.scroll_start = cmd.exec_put && status.scroll_needed;
      cmd.scroll_step  = (state_ff == ST_SCROLL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.exec_put || cmd.load_read) begin
            rsp_valid_ff <= 1'b1;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (status.sweep_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (status.kind_read) begin
                  state_ff <= ST_READ_DONE;
               end else if (status.scroll_needed) begin
                  state_ff <= ST_SCROLL;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_READ_DONE: begin
               state_ff <= ST_IDLE;
            end
            ST_SCROLL: begin
               if (status.sweep_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   `ASSERT_CLK(a_reset_clear, clock, reset |=> (state_ff == ST_CLEAR) && !rsp_valid_ff, "reset did not start the clearing pass")
   `ASSERT_CLKD(a_accept_exec, clock, reset, accept |=> state_ff == ST_EXEC, "accepted beat not executed")
   `ASSERT_CLKD(a_rsp_source, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC) || $past(state_ff == ST_READ_DONE), "result raised outside execute")

endmodule

// ===== rtl/text_console_writer_core.sv =====
// text-mode console engine: a screen of ROWS x COLUMNS cells (character in the low byte,
// colour attribute in the high byte) held in one on-chip memory with one write and one
// registered read port. A put beat writes a character at the write position with the
// text_color register, or moves to the next line on a newline; a read beat returns one
// cell (zero outside the screen). Every beat returns one result beat with the cursor
// register and, for reads, the cell. After reset the block runs a clearing pass over all
// cells writing blank cells and takes no beat meanwhile; the colour register can be
// written at any time. A put goes through the execute state to its result; a read
// issues the registered memory read in execute and loads the cell in read completion.
// Moving past the last row scrolls the screen: one sweep over every cell copies each row
// up through the memory and blanks the bottom row, and no new beat is taken until it
// ends. A new beat is taken only once the previous result has left or is leaving.
module text_console_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                               clock,
   input  logic                               reset,
   tcw_req_if.sink                            req,
   tcw_rsp_if.source                          rsp,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   tcw_pkg::dp_cmd_type          cmd;
   tcw_pkg::dp_status_type       status;
   logic [tcw_pkg::COLOR_W-1:0]  text_color_ff;
   logic [tcw_pkg::CSR_IDX_W-1:0] csr_idx;
   logic                         csr_write;

   // register file: one colour register, word addressed
   assign pready    = 1'b1;
   assign csr_idx   = paddr[tcw_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= tcw_pkg::RESET_COLOR;
      end else if (csr_write && (csr_idx == tcw_pkg::REG_TEXT_COLOR)) begin
         text_color_ff <= pwdata[tcw_pkg::COLOR_W-1:0];
      end
   end

   // unused addresses read as zero
   always_comb begin
      prdata = '0;
      if (csr_idx == tcw_pkg::REG_TEXT_COLOR) begin
         prdata = tcw_pkg::CSR_DATA_W'(text_color_ff);
      end
   end

   // sequencing: clearing pass, execute, read completion and scroll sweep
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // screen memory, write position, cursor register and result register
   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_kind            (req.kind),
      .req_char_code       (req.char_code),
      .req_read_row        (req.read_row),
      .req_read_col        (req.read_col),
      .text_color          (text_color_ff),
      .rsp_cursor_position (rsp.cursor_position),
      .rsp_cell_value      (rsp.cell_value)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int SCREEN_CELLS = ROWS * COLUMNS;
   // a scroll sweep touches every cell once, so this covers any work left after a result
   localparam int SETTLE_CYCLES = SCREEN_CELLS + 64;
   localparam int LONG_HOLD     = 400;
   localparam longint unsigned CYCLE_LIMIT = 20_000_000;

   // one request beat, field for field as on the channel
   typedef struct packed {
      logic                         kind;
      logic [tcw_pkg::CHAR_W-1:0]   char_code;
      logic [tcw_pkg::ROW_IN_W-1:0] read_row;
      logic [tcw_pkg::COL_IN_W-1:0] read_col;
   } console_cmd_type;

   // one result beat: cursor register and the cell read back
   typedef struct packed {
      logic [tcw_pkg::CURSOR_W-1:0] cursor;
      logic [tcw_pkg::CELL_W-1:0]   cell_word;
   } console_view_type;

   bit   clock;
   logic reset = 1'b1;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [tcw_pkg::CSR_ADDR_W-1:0] paddr;
   logic [tcw_pkg::CSR_DATA_W-1:0] pwdata;
   logic [tcw_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   text_console_writer_core #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // 10 ns clock, first rising edge at 5 ns
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // screen model: our own copy of the cells, write position, cursor and colour
   // ------------------------------------------------------------------
   logic [tcw_pkg::CELL_W-1:0]   screen_model [SCREEN_CELLS];
   int unsigned                  pen_row;
   int unsigned                  pen_col;
   logic [tcw_pkg::CURSOR_W-1:0] cursor_model;
   logic [tcw_pkg::COLOR_W-1:0]  color_model;

   // go to column 0 of the next row; past the bottom, shift everything up a row
   function automatic void advance_line();
      pen_col = 0;
      pen_row++;
      if (pen_row >= ROWS) begin
         for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
         // the freed bottom row takes the colour in force at the time of the scroll
         for (int i = (ROWS - 1) * COLUMNS; i < SCREEN_CELLS; i++)
            screen_model[i] = {color_model, tcw_pkg::SPACE_CODE};
         pen_row = ROWS - 1;
      end
   endfunction

   // apply one accepted beat to the model and return the result it must produce
   function automatic console_view_type console_step(console_cmd_type cmd);
      console_view_type view;
      view.cell_word = '0;
      if (cmd.kind == tcw_pkg::KIND_PUT) begin
         if (cmd.char_code == tcw_pkg::NEWLINE_CODE) begin
            advance_line();
            cursor_model = tcw_pkg::CURSOR_W'(pen_row * COLUMNS);
         end else begin
            screen_model[pen_row * COLUMNS + pen_col] = {color_model, cmd.char_code};
            // cursor lands just past the written cell, even at the row end, and a
            // wrap (with or without a scroll) leaves it where it is
            cursor_model = tcw_pkg::CURSOR_W'(pen_row * COLUMNS + pen_col + 1);
            pen_col++;
            if (pen_col >= COLUMNS)
               advance_line();
         end
      end else if (cmd.read_row < ROWS && cmd.read_col < COLUMNS) begin
         view.cell_word = screen_model[cmd.read_row * COLUMNS + cmd.read_col];
      end
      // out-of-range reads give an empty cell and leave the state alone
      view.cursor = cursor_model;
      return view;
   endfunction

   // ------------------------------------------------------------------
   // beat queues and bookkeeping
   // ------------------------------------------------------------------
   console_cmd_type  keystroke_q [$];    // beats waiting for the driver
   console_view_type screen_view_q [$];  // results owed by the block, oldest first
   int unsigned      beats_queued;
   int unsigned      beats_taken;
   int unsigned      mismatch_count;
   longint unsigned  cycle_count;

   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   bit          req_fire;               // request beat accepted at the last rising edge
   bit          hold_wanted;
   bit          hold_done;
   int unsigned hold_left;

   // ------------------------------------------------------------------
   // request driver: changes on the falling edge, one beat at a time
   // ------------------------------------------------------------------
   always @(negedge clock) begin : request_driver
      console_cmd_type next_cmd;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         // previous beat gone (or none offered): offer the next one unless we idle
         if (keystroke_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_cmd = keystroke_q.pop_front();
            req_bus.kind      <= next_cmd.kind;
            req_bus.char_code <= next_cmd.char_code;
            req_bus.read_row  <= next_cmd.read_row;
            req_bus.read_col  <= next_cmd.read_col;
            req_bus.valid     <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // result receiver: random back-pressure plus one long hold-off on request
   // ------------------------------------------------------------------
   always @(negedge clock) begin : result_receiver
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_wanted && !hold_done) begin
         // long stall so the block backs up and stops taking requests
         hold_left     <= LONG_HOLD;
         hold_done     <= 1'b1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // monitor: both channels sampled on the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : beat_monitor
      console_cmd_type  got_cmd;
      console_view_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            got_cmd.kind      = req_bus.kind;
            got_cmd.char_code = req_bus.char_code;
            got_cmd.read_row  = req_bus.read_row;
            got_cmd.read_col  = req_bus.read_col;
            screen_view_q.push_back(console_step(got_cmd));
            beats_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (screen_view_q.size() == 0) begin
               $display("%0t: result beat with nothing owed: cursor %0d cell %h",
                        $time, rsp_bus.cursor_position, rsp_bus.cell_value);
               mismatch_count++;
            end else begin
               want = screen_view_q.pop_front();
               if (rsp_bus.cursor_position !== want.cursor) begin
                  $display("%0t: cursor_position expected %0d got %0d",
                           $time, want.cursor, rsp_bus.cursor_position);
                  mismatch_count++;
               end
               if (rsp_bus.cell_value !== want.cell_word) begin
                  $display("%0t: cell_value expected %h got %h",
                           $time, want.cell_word, rsp_bus.cell_value);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic console_cmd_type beat_of(logic k, logic [tcw_pkg::CHAR_W-1:0] ch,
                                               logic [tcw_pkg::ROW_IN_W-1:0] r,
                                               logic [tcw_pkg::COL_IN_W-1:0] c);
      console_cmd_type b;
      b.kind      = k;
      b.char_code = ch;
      b.read_row  = r;
      b.read_col  = c;
      return b;
   endfunction

   task automatic queue_beat(console_cmd_type b);
      keystroke_q.push_back(b);
      beats_queued++;
   endtask

   // put beats carry junk in the read fields, which the block must ignore
   task automatic put_char(logic [tcw_pkg::CHAR_W-1:0] ch);
      queue_beat(beat_of(tcw_pkg::KIND_PUT, ch, tcw_pkg::ROW_IN_W'($urandom_range(0, 31)),
                         tcw_pkg::COL_IN_W'($urandom_range(0, 127))));
   endtask

   task automatic read_cell(int unsigned r, int unsigned c);
      queue_beat(beat_of(tcw_pkg::KIND_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                         tcw_pkg::ROW_IN_W'(r), tcw_pkg::COL_IN_W'(c)));
   endtask

   // wait until every queued beat is taken and every result has come back
   task automatic wait_for_idle();
      do @(negedge clock);
      while (beats_taken != beats_queued || screen_view_q.size() != 0);
   endtask

   // colour register write then read-back; only called with the block idle
   task automatic set_text_color(logic [tcw_pkg::COLOR_W-1:0] color);
      // a scroll sweep may still be running after its result beat
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {tcw_pkg::REG_TEXT_COLOR, 2'b00};
      pwdata  = tcw_pkg::CSR_DATA_W'(color);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock);
      while (!pready);
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock);
      while (!pready);
      if (prdata[tcw_pkg::COLOR_W-1:0] !== color) begin
         $display("%0t: text_color read-back expected %h got %h",
                  $time, color, prdata[tcw_pkg::COLOR_W-1:0]);
         mismatch_count++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      color_model = color;
   endtask

   // mostly printable text, sometimes any byte at all (newline included)
   function automatic logic [tcw_pkg::CHAR_W-1:0] text_byte();
      if ($urandom_range(99) < 80)
         return tcw_pkg::CHAR_W'($urandom_range(32, 126));
      return tcw_pkg::CHAR_W'($urandom_range(0, 255));
   endfunction

   // reads lean towards the bottom rows and left columns where text tends to sit
   task automatic random_read();
      int unsigned r;
      int unsigned c;
      r = $urandom_range(99);
      if (r < 45)      r = $urandom_range(ROWS - 4, ROWS - 1);
      else if (r < 85) r = $urandom_range(0, ROWS - 1);
      else             r = $urandom_range(0, 31);
      c = $urandom_range(99);
      if (c < 50)      c = $urandom_range(0, 20);
      else if (c < 85) c = $urandom_range(0, COLUMNS - 1);
      else             c = $urandom_range(0, 127);
      read_cell(r, c);
   endtask

   // random traffic built from short episodes: text runs, line feeds, read bursts, noise
   task automatic queue_random(int unsigned target);
      int unsigned start;
      int unsigned pick;
      int unsigned len;
      start = beats_queued;
      while (beats_queued - start < target) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            // text run, now and then long enough to wrap a row
            len = ($urandom_range(4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 16);
            repeat (len) put_char(text_byte());
            if ($urandom_range(1) == 1)
               put_char(tcw_pkg::NEWLINE_CODE);
         end else if (pick < 55) begin
            repeat ($urandom_range(1, 3)) put_char(tcw_pkg::NEWLINE_CODE);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 6)) random_read();
         end else begin
            // noise: every field random over its full width
            queue_beat(beat_of(1'($urandom_range(0, 1)),
                               tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                               tcw_pkg::ROW_IN_W'($urandom_range(0, 31)),
                               tcw_pkg::COL_IN_W'($urandom_range(0, 127))));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // run-time limit
   // ------------------------------------------------------------------
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_bus.valid     = 1'b0;
      req_bus.kind      = tcw_pkg::KIND_PUT;
      req_bus.char_code = '0;
      req_bus.read_row  = '0;
      req_bus.read_col  = '0;
      rsp_bus.ready     = 1'b0;

      // model state after reset: blank screen in the default colour
      for (int i = 0; i < SCREEN_CELLS; i++)
         screen_model[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::SPACE_CODE};
      pen_row      = 0;
      pen_col      = 0;
      cursor_model = '0;
      color_model  = tcw_pkg::RESET_COLOR;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // phase 1: sender idles 38 %, receiver 69 %, default colour
      sender_idle_pct   = 38;
      receiver_idle_pct = 69;

      // directed: blank screen, byte extremes, newline, junk read fields, bad reads
      read_cell(0, 0);
      read_cell(ROWS - 1, COLUMNS - 1);
      put_char(8'h00);
      put_char(8'hFF);
      queue_beat(beat_of(tcw_pkg::KIND_PUT, 8'h41, 5'd31, 7'd127));
      put_char(tcw_pkg::NEWLINE_CODE);
      put_char(tcw_pkg::SPACE_CODE);
      put_char(8'h7F);
      put_char(8'h80);
      put_char(8'h09);
      put_char(8'h0B);
      read_cell(0, 0);
      read_cell(0, 1);
      read_cell(0, 2);
      read_cell(0, 3);
      read_cell(1, 0);
      read_cell(1, 4);
      read_cell(ROWS, 0);                              // row just off the screen
      read_cell(0, COLUMNS);                           // column just off the screen
      queue_beat(beat_of(tcw_pkg::KIND_READ, 8'hFF, 5'd31, 7'd127));
      // newline code on a read is inert
      queue_beat(beat_of(tcw_pkg::KIND_READ, tcw_pkg::NEWLINE_CODE, '0, '0));

      // fill past a row end, then feed lines until the screen scrolls three times
      repeat (85) put_char(tcw_pkg::CHAR_W'($urandom_range(33, 126)));
      read_cell(1, COLUMNS - 1);
      read_cell(2, 0);
      read_cell(2, 4);
      repeat (25) put_char(tcw_pkg::NEWLINE_CODE);
      read_cell(ROWS - 1, 0);
      read_cell(ROWS - 2, 3);
      read_cell(0, 0);

      queue_random(200);
      wait_for_idle();

      // phase 2: black on black, same idling
      set_text_color(8'h00);
      queue_random(210);
      wait_for_idle();

      // phase 3: idling swapped, all attribute bits set
      sender_idle_pct   = 69;
      receiver_idle_pct = 38;
      set_text_color(8'hFF);
      queue_random(210);
      wait_for_idle();

      // phase 4: random colour, with a full pause of the sender half way
      set_text_color(tcw_pkg::COLOR_W'($urandom_range(0, 255)));
      queue_random(120);
      wait_for_idle();
      queue_random(120);
      wait_for_idle();

      // phase 5: no idling, and a long receiver stall while beats keep coming
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      set_text_color(tcw_pkg::COLOR_W'($urandom_range(0, 255)));
      queue_random(250);
      hold_wanted = 1'b1;
      wait_for_idle();

      // let any trailing scroll finish and catch stray result beats
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== text_console_writer_core.f =====
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_datapath.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_core.sv
tb/testbench.sv
